// ===== hw/rtl/fkprs_pkg.sv =====
// shared types and constants for the four-key press and repeat scanner
package fkprs_pkg;

  localparam int TIME_BITS = 32;
  localparam int NOW_BITS  = 32;
  localparam int CFG_BITS  = 16;
  localparam int IDX_BITS  = 2;
  localparam int EV_BITS   = 3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_BITS-1:0]  cfg_val_t;
  typedef logic [IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [EV_BITS-1:0]   ev_t;

  localparam ev_t EV_NONE       = 3'd0;
  localparam ev_t EV_ENTER_LONG = 3'd1;
  localparam ev_t EV_ENTER      = 3'd2;
  localparam ev_t EV_BACK       = 3'd3;
  localparam ev_t EV_DOWN       = 3'd4;
  localparam ev_t EV_UP         = 3'd5;

  localparam cfg_idx_t CFG_LONG_PRESS      = 2'd0;
  localparam cfg_idx_t CFG_REPEAT_DELAY    = 2'd1;
  localparam cfg_idx_t CFG_REPEAT_INTERVAL = 2'd2;

  localparam cfg_val_t LONG_PRESS_RST      = 16'd800;
  localparam cfg_val_t REPEAT_DELAY_RST    = 16'd400;
  localparam cfg_val_t REPEAT_INTERVAL_RST = 16'd100;

  typedef struct packed {
    logic [NOW_BITS-1:0] now_ms;
    logic                enter_level;
    logic                enter_confirm;
    logic                back_level;
    logic                back_confirm;
    logic                down_level;
    logic                down_confirm;
    logic                up_level;
    logic                up_confirm;
  } poll_t;

  typedef struct packed {
    cfg_val_t long_press_ms;
    cfg_val_t repeat_delay_ms;
    cfg_val_t repeat_interval_ms;
  } cfg_t;

  typedef struct packed {
    time_t hold_start_time;
    logic  enter_held;
    logic  back_held;
    logic  down_held;
    logic  up_held;
    time_t down_next_repeat;
    time_t up_next_repeat;
  } scan_state_t;

endpackage

// ===== hw/rtl/fkprs_in_if.sv =====
// poll channel: time and two samples of each key
interface fkprs_in_if;
  import fkprs_pkg::*;
  logic                valid;
  logic                ready;
  logic [NOW_BITS-1:0] now_ms;
  logic                enter_level;
  logic                enter_confirm;
  logic                back_level;
  logic                back_confirm;
  logic                down_level;
  logic                down_confirm;
  logic                up_level;
  logic                up_confirm;

  modport source (
    output valid, now_ms, enter_level, enter_confirm, back_level, back_confirm,
           down_level, down_confirm, up_level, up_confirm,
    input  ready
  );
  modport sink (
    input  valid, now_ms, enter_level, enter_confirm, back_level, back_confirm,
           down_level, down_confirm, up_level, up_confirm,
    output ready
  );
endinterface

// ===== hw/rtl/fkprs_out_if.sv =====
// event channel: one key event per poll
interface fkprs_out_if;
  import fkprs_pkg::*;
  logic valid;
  logic ready;
  ev_t  key_event;

  modport source (output valid, key_event, input ready);
  modport sink (input valid, key_event, output ready);
endinterface

// ===== hw/rtl/fkprs_cfg_if.sv =====
// configuration write channel: register index and data
interface fkprs_cfg_if;
  import fkprs_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_val_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/four_key_press_repeat_scanner.sv =====
// top level of the four-key press and repeat scanner
//
// channel  dir  payload                                    word
// in_ch    in   now_ms, level and confirm of four keys     one poll
// out_ch   out  key_event                                  one event
// cfg_ch   in   index, data                                one register write
//
// a poll is registered on accept, scanned in the next cycle and its event
// lands in the output register; one poll per cycle sustained while out_ch is ready
// key state updates when the event is loaded into the output register
// a stalled output holds the event; the input register still takes one poll
// synchronous active-low reset restores register defaults and clears key state
module four_key_press_repeat_scanner
  import fkprs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  fkprs_in_if.sink    in_ch,
  fkprs_out_if.source out_ch,
  fkprs_cfg_if.sink   cfg_ch
);

  poll_t       poll_r;
  logic        poll_v_r;
  ev_t         ev_r;
  logic        ev_v_r;
  cfg_t        cfg_r;
  scan_state_t st_r;
  scan_state_t st_nxt;
  ev_t         ev_nxt;
  logic        advance;
  logic        in_take;
  poll_t       poll_in;

  assign advance   = !ev_v_r || out_ch.ready;
  assign in_ch.ready = !poll_v_r || advance;
  assign in_take   = in_ch.valid && in_ch.ready;

  assign poll_in.now_ms        = in_ch.now_ms;
  assign poll_in.enter_level   = in_ch.enter_level;
  assign poll_in.enter_confirm = in_ch.enter_confirm;
  assign poll_in.back_level    = in_ch.back_level;
  assign poll_in.back_confirm  = in_ch.back_confirm;
  assign poll_in.down_level    = in_ch.down_level;
  assign poll_in.down_confirm  = in_ch.down_confirm;
  assign poll_in.up_level      = in_ch.up_level;
  assign poll_in.up_confirm    = in_ch.up_confirm;

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = ev_v_r;
  assign out_ch.key_event = ev_r;

  fkprs_evt u_evt (
    .poll      (poll_r),
    .cfg       (cfg_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .key_event (ev_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      poll_v_r <= in_ch.valid;
    end
    if (in_take) begin
      poll_r <= poll_in;
    end
  end

  // output register and key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_v_r <= 1'b0;
      st_r   <= '0;
    end else if (advance) begin
      ev_v_r <= poll_v_r;
      if (poll_v_r) begin
        st_r <= st_nxt;
      end
    end
    if (advance && poll_v_r) begin
      ev_r <= ev_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms      <= LONG_PRESS_RST;
      cfg_r.repeat_delay_ms    <= REPEAT_DELAY_RST;
      cfg_r.repeat_interval_ms <= REPEAT_INTERVAL_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_LONG_PRESS:      cfg_r.long_press_ms      <= cfg_ch.data;
        CFG_REPEAT_DELAY:    cfg_r.repeat_delay_ms    <= cfg_ch.data;
        CFG_REPEAT_INTERVAL: cfg_r.repeat_interval_ms <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/fkprs_evt.sv =====
// key scan logic: picks the event and next key state for one poll
module fkprs_evt
  import fkprs_pkg::*;
(
  input  poll_t       poll,
  input  cfg_t        cfg,
  input  scan_state_t st,
  output scan_state_t st_nxt,
  output ev_t         key_event
);

  time_t t;
  time_t hold_diff;
  time_t down_diff;
  time_t up_diff;
  time_t delay_t;
  time_t interval_t;

  assign t          = TIME_BITS'(poll.now_ms);
  assign hold_diff  = t - st.hold_start_time;
  assign down_diff  = t - st.down_next_repeat;
  assign up_diff    = t - st.up_next_repeat;
  assign delay_t    = TIME_BITS'(cfg.repeat_delay_ms);
  assign interval_t = TIME_BITS'(cfg.repeat_interval_ms);

  always_comb begin
    st_nxt    = st;
    key_event = EV_NONE;

    if (!poll.enter_level) begin
      if (hold_diff > TIME_BITS'(cfg.long_press_ms)) begin
        st_nxt.hold_start_time = t;
        key_event = EV_ENTER_LONG;
      end
    end else begin
      st_nxt.hold_start_time = t;
    end

    if (key_event == EV_NONE) begin
      if (!poll.enter_level) begin
        if (!poll.enter_confirm && !st.enter_held) begin
          st_nxt.enter_held = 1'b1;
          key_event = EV_ENTER;
        end
      end else begin
        st_nxt.enter_held = 1'b0;
      end
    end

    if (key_event == EV_NONE) begin
      if (!poll.back_level) begin
        if (!poll.back_confirm && !st.back_held) begin
          st_nxt.back_held = 1'b1;
          key_event = EV_BACK;
        end
      end else begin
        st_nxt.back_held = 1'b0;
      end
    end

    if (key_event == EV_NONE) begin
      if (!poll.down_level) begin
        if (!poll.down_confirm) begin
          if (!st.down_held) begin
            st_nxt.down_held        = 1'b1;
            st_nxt.down_next_repeat = t + delay_t;
            key_event = EV_DOWN;
          end else if (!down_diff[TIME_BITS-1]) begin
            st_nxt.down_next_repeat = t + interval_t;
            key_event = EV_DOWN;
          end
        end
      end else begin
        st_nxt.down_held        = 1'b0;
        st_nxt.down_next_repeat = '0;
      end
    end

    if (key_event == EV_NONE) begin
      if (!poll.up_level) begin
        if (!poll.up_confirm) begin
          if (!st.up_held) begin
            st_nxt.up_held        = 1'b1;
            st_nxt.up_next_repeat = t + delay_t;
            key_event = EV_UP;
          end else if (!up_diff[TIME_BITS-1]) begin
            st_nxt.up_next_repeat = t + interval_t;
            key_event = EV_UP;
          end
        end
      end else begin
        st_nxt.up_held        = 1'b0;
        st_nxt.up_next_repeat = '0;
      end
    end
  end

endmodule
